[hdl/rhsd_pkg.sv]
// Shared types and constants for the RSSI history signal detector.
// No dependencies.
package rhsd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_SCAN,
    ST_DIV,
    ST_SCORE,
    ST_OUT
  } rhsd_state_t;

  localparam logic [1:0] REG_FREQ_LOW  = 2'd0;
  localparam logic [1:0] REG_FREQ_HIGH = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic [15:0] FREQ_LOW_RST  = 16'd5645;
  localparam logic [15:0] FREQ_HIGH_RST = 16'd5945;
  localparam logic [7:0]  THRESH_RST    = 8'd50;

  // Maps a rate or spread onto the 80/60/40 band score.
  function automatic logic [6:0] band_score(input logic [15:0] v);
    if (v > 16'd20 && v < 16'd60) return 7'd80;
    else if (v > 16'd10 && v < 16'd80) return 7'd60;
    else return 7'd40;
  endfunction

endpackage

[hdl/rhsd_if.sv]
// Valid/ready channel interfaces for input items and results.
// Depends on nothing.
interface rhsd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frequency;
  logic [7:0]  rssi_sample;
  modport source (output valid, frequency, rssi_sample, input ready);
  modport sink   (input valid, frequency, rssi_sample, output ready);
endinterface

interface rhsd_out_if;
  logic       valid;
  logic       ready;
  logic       in_range;
  logic [7:0] adj_rssi;
  logic [7:0] smoothed_rssi;
  logic [6:0] trend_score;
  logic [6:0] stability_score;
  logic [6:0] fpv_score;
  logic       video_detected;
  logic [7:0] low_rssi;
  logic [7:0] peak_rssi;
  logic [7:0] mean_rssi;
  logic [5:0] valid_count;
  modport source (output valid, in_range, adj_rssi, smoothed_rssi, trend_score,
                  stability_score, fpv_score, video_detected, low_rssi, peak_rssi,
                  mean_rssi, valid_count, input ready);
  modport sink   (input valid, in_range, adj_rssi, smoothed_rssi, trend_score,
                  stability_score, fpv_score, video_detected, low_rssi, peak_rssi,
                  mean_rssi, valid_count, output ready);
endinterface

[hdl/rhsd_divider.sv]
// Restoring divider, one quotient bit per cycle.
// Uses no package items.
module rhsd_divider #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt, quo_r, quo_nxt, den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0]    trial;

  always_comb begin
    trial   = {rem_r, quo_r[W-1]};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CW'(W);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) den_r <= divisor;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;
endmodule

[hdl/rssi_history_signal_detector_top.sv]
// RSSI history signal detector: per-channel ring history in one RAM, scores per sample.
// Per item, from input transfer to result valid: read, history scan, four serial 16-bit
// divisions and the score state.
// One item at a time: the next input is taken only once the previous result has been accepted.
// Out-of-range items give an all-zero result the cycle after transfer. After reset a clearing
// pass over all CHANNELS * 2**clog2(SAMPLES) history entries zeroes the RAMs; cfg registers take defaults.
module rssi_history_signal_detector_top
  import rhsd_pkg::*;
#(
  parameter int CHANNELS = 512,
  parameter int SAMPLES  = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  rhsd_in_if.sink    in_ch,
  rhsd_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int CHW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW     = $clog2(SAMPLES);
  localparam int AW     = CHW + SW;
  localparam int HDEPTH = CHANNELS << SW;
  localparam int CNTW   = $clog2(SAMPLES + 1);
  localparam int SUMW   = $clog2(SAMPLES * 255 + 1);
  localparam int REC    = (SAMPLES * 8) / 10;
  localparam int HALF   = SAMPLES / 2;

  logic [15:0] freq_low_r, freq_high_r;
  logic [7:0]  thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_low_r  <= FREQ_LOW_RST;
      freq_high_r <= FREQ_HIGH_RST;
      thresh_r    <= THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FREQ_LOW:  freq_low_r  <= cfg_data;
        REG_FREQ_HIGH: freq_high_r <= cfg_data;
        REG_THRESHOLD: thresh_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // memories
  logic [7:0]    hist_mem [HDEPTH];
  logic [SW-1:0] wpos_mem [CHANNELS];
  logic [7:0]    smooth_mem [CHANNELS];
  logic          hist_we, side_we;
  logic [AW-1:0] hist_waddr, hist_raddr;
  logic [7:0]    hist_wdata, hist_rdata_r;
  logic [SW-1:0] wpos_rdata_r, wpos_wdata;
  logic [7:0]    smooth_rdata_r, smooth_wdata;
  logic [CHW-1:0] side_addr;

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rdata_r <= hist_mem[hist_raddr];
    if (side_we) begin
      wpos_mem[side_addr]   <= wpos_wdata;
      smooth_mem[side_addr] <= smooth_wdata;
    end
    wpos_rdata_r   <= wpos_mem[side_addr];
    smooth_rdata_r <= smooth_mem[side_addr];
  end

  rhsd_state_t state_r, state_nxt;
  logic [AW:0]    clr_r;
  logic [CHW-1:0] ch_r;
  logic [7:0]     samp_r;
  logic [CNTW:0]  idx_r;   // scan index, includes read-latency slot
  logic [SW-1:0]  pos_r;
  logic [7:0]     prev2_r, prev1_r;
  logic [SUMW-1:0] sum_r, rsum_r, osum_r;
  logic [CNTW-1:0] cnt_r, rcnt_r, ocnt_r, pairs_r, chg_r;
  logic [7:0]     mn_r, mx_r;
  logic [4:0]     peaks_r;
  logic [2:0]     dstep_r;
  logic [7:0]     avg_r, ravg_r, oavg_r, rate_r, smooth_r;
  logic           dstart_r, range_r;
  logic           dbusy;
  logic [15:0]    dquo;
  logic [15:0]    dend, dsor;
  logic [16:0]    offs;
  logic           hit;
  logic [7:0]     lvl_new;

  assign offs = {1'b0, in_ch.frequency} - {1'b0, freq_low_r};
  assign hit  = in_ch.frequency >= freq_low_r && in_ch.frequency <= freq_high_r &&
                offs < 17'(CHANNELS);

  // level after this sample: the new mean, or the old level when the history is empty
  assign lvl_new = (cnt_r != '0) ? avg_r : smooth_r;

  rhsd_divider #(.W(16)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart_r), .dividend(dend), .divisor(dsor),
    .busy(dbusy), .quotient(dquo)
  );

  // current sample value at scan position k = idx_r-1 (registered RAM read)
  logic [SW:0] k;
  logic [7:0]  v;
  logic        scan_rd;
  assign k = idx_r[SW:0] - 1'b1;
  assign v = (k[SW-1:0] == pos_r) ? samp_r : hist_rdata_r; // forward the new write
  assign scan_rd = (idx_r != '0) && (idx_r <= (CNTW+1)'(SAMPLES));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == (AW+1)'(HDEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_ch.valid) state_nxt = hit ? ST_READ : ST_OUT;
      ST_READ:  state_nxt = ST_SCAN;
      ST_SCAN:  if (idx_r == (CNTW+1)'(SAMPLES)) state_nxt = ST_DIV;
      ST_DIV:   if (dstep_r == 3'd4 && !dbusy && !dstart_r) state_nxt = ST_SCORE;
      ST_SCORE: state_nxt = ST_OUT;
      ST_OUT:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = {ch_r, pos_r};
    hist_wdata = samp_r;
    hist_raddr = {ch_r, idx_r[SW-1:0]};
    side_we    = 1'b0;
    side_addr  = ch_r;
    wpos_wdata = (pos_r == SW'(SAMPLES - 1)) ? '0 : SW'(pos_r + 1'b1);
    smooth_wdata = smooth_r;
    if (state_r == ST_CLEAR) begin
      hist_we    = 1'b1;
      hist_waddr = clr_r[AW-1:0];
      hist_wdata = '0;
      side_we    = (clr_r < (AW+1)'(CHANNELS));
      side_addr  = clr_r[CHW-1:0];
      wpos_wdata = '0;
      smooth_wdata = '0;
    end else if (state_r == ST_IDLE) begin
      side_addr = offs[CHW-1:0];
    end else if (state_r == ST_SCAN && idx_r == '0) begin
      // pos_r is loaded at this edge, so address from the read data directly
      hist_we    = 1'b1;
      hist_waddr = {ch_r, wpos_rdata_r};
      side_we    = 1'b1;
      wpos_wdata = (wpos_rdata_r == SW'(SAMPLES - 1)) ? '0 : SW'(wpos_rdata_r + 1'b1);
      smooth_wdata = smooth_rdata_r;
    end else if (state_r == ST_SCORE) begin
      side_we = 1'b1;
      smooth_wdata = lvl_new;
    end
  end

  always_comb begin
    unique case (dstep_r)
      3'd0: begin dend = 16'(sum_r);  dsor = 16'(cnt_r); end
      3'd1: begin dend = 16'(rsum_r); dsor = 16'(rcnt_r); end
      3'd2: begin dend = 16'(osum_r); dsor = 16'(ocnt_r); end
      default: begin dend = 16'(chg_r) * 16'd100; dsor = 16'(pairs_r); end
    endcase
  end

  // scoring
  logic [7:0] corr, spread;
  logic [6:0] trend, stab, modu, chg, peri, fpv;
  logic [7:0] dd, qd;
  logic [8:0] csum;
  logic [15:0] wsum;
  always_comb begin
    dd = '0;
    qd = '0;
    if (rcnt_r == '0 || ocnt_r == '0) trend = 7'd50;
    else if (ravg_r > oavg_r) begin
      dd = ravg_r - oavg_r; qd = dd >> 2; trend = 7'(8'd50 + qd);
    end else begin
      dd = oavg_r - ravg_r; qd = dd >> 2;
      trend = (qd > 8'd50) ? 7'd0 : 7'(8'd50 - qd);
    end
    csum = {1'b0, samp_r} + {1'b0, lvl_new};
    corr = (trend > 7'd50) ? csum[8:1] : samp_r;
    spread = mx_r - mn_r;
    if (cnt_r < CNTW'(5)) begin stab = '0; modu = '0; end
    else begin
      stab = spread < 8'd20 ? 7'd100 : spread < 8'd40 ? 7'd80 : spread < 8'd60 ? 7'd60 : 7'd40;
      modu = band_score(16'(spread));
    end
    chg  = (pairs_r < CNTW'(5)) ? 7'd0 : band_score(16'(rate_r));
    peri = (peaks_r > 5'd9) ? 7'd100 : 7'(7'(peaks_r) * 7'd10);
    // divide by 3 via reciprocal, exact for sums up to 300
    fpv  = 7'((17'(peri) + 17'(modu) + 17'(chg)) * 17'd171 >> 9);
    wsum = 16'(corr) * 16'd40 + 16'(stab) * 16'd30 + 16'(fpv) * 16'd30;
  end

  logic [7:0] o_corr, o_sm, o_mn, o_mx, o_avg;
  logic [6:0] o_tr, o_st, o_fpv;
  logic       o_det;
  logic [5:0] o_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      dstart_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      dstart_r <= (state_r == ST_SCAN && state_nxt == ST_DIV) ||
                  (state_r == ST_DIV && !dbusy && !dstart_r && dstep_r < 3'd3);
    end
    if (state_r == ST_IDLE && in_ch.valid) begin
      ch_r <= offs[CHW-1:0]; samp_r <= in_ch.rssi_sample; range_r <= hit;
      idx_r <= '0; sum_r <= '0; rsum_r <= '0; osum_r <= '0; cnt_r <= '0; rcnt_r <= '0;
      ocnt_r <= '0; pairs_r <= '0; chg_r <= '0; mn_r <= 8'd255; mx_r <= '0;
      peaks_r <= '0; dstep_r <= '0; prev1_r <= '0; prev2_r <= '0;
      o_corr <= '0; o_sm <= '0; o_tr <= '0; o_st <= '0; o_fpv <= '0; o_det <= 1'b0;
      o_mn <= '0; o_mx <= '0; o_avg <= '0; o_cnt <= '0;
    end
    if (state_r == ST_READ) idx_r <= '0;
    if (state_r == ST_SCAN) begin
      if (idx_r == '0) begin pos_r <= wpos_rdata_r; smooth_r <= smooth_rdata_r; end
      idx_r <= idx_r + 1'b1;
      if (scan_rd) begin
        if (v != 8'd0) begin
          sum_r <= sum_r + SUMW'(v); cnt_r <= cnt_r + 1'b1;
          if (v < mn_r) mn_r <= v;
          if (v > mx_r) mx_r <= v;
          if (k >= (SW+1)'(REC)) begin
            rsum_r <= rsum_r + SUMW'(v); rcnt_r <= rcnt_r + 1'b1;
          end
          if (k < (SW+1)'(HALF)) begin
            osum_r <= osum_r + SUMW'(v); ocnt_r <= ocnt_r + 1'b1;
          end
        end
        if (k != '0 && v != 8'd0 && prev1_r != 8'd0) begin
          pairs_r <= pairs_r + 1'b1;
          if ((v > prev1_r ? v - prev1_r : prev1_r - v) > 8'd5) chg_r <= chg_r + 1'b1;
        end
        if (k >= (SW+1)'(2) && prev1_r != 8'd0 &&
            ((prev1_r > prev2_r && prev1_r > v) || (prev1_r < prev2_r && prev1_r < v)) &&
            peaks_r != 5'd31)
          peaks_r <= peaks_r + 1'b1;
        prev2_r <= prev1_r; prev1_r <= v;
      end
    end
    // each quotient is taken once its division has finished
    if (state_r == ST_DIV && !dbusy && !dstart_r && dstep_r != 3'd4) begin
      unique case (dstep_r)
        3'd0: avg_r  <= (cnt_r == '0) ? 8'd0 : dquo[7:0];
        3'd1: ravg_r <= dquo[7:0];
        3'd2: oavg_r <= dquo[7:0];
        3'd3: rate_r <= (pairs_r == '0) ? 8'd0 : dquo[7:0];
        default: ;
      endcase
      dstep_r <= dstep_r + 1'b1;
    end
    if (state_r == ST_SCORE) begin
      o_corr <= corr; o_sm <= lvl_new; o_tr <= trend; o_st <= stab; o_fpv <= fpv;
      o_det <= (corr >= thresh_r) && (wsum > 16'd6099);
      o_mn <= mn_r; o_mx <= mx_r; o_avg <= avg_r; o_cnt <= 6'(cnt_r);
    end
  end

  assign out_ch.in_range        = range_r;
  assign out_ch.adj_rssi        = o_corr;
  assign out_ch.smoothed_rssi   = o_sm;
  assign out_ch.trend_score     = o_tr;
  assign out_ch.stability_score = o_st;
  assign out_ch.fpv_score       = o_fpv;
  assign out_ch.video_detected  = o_det;
  assign out_ch.low_rssi        = o_mn;
  assign out_ch.peak_rssi       = o_mx;
  assign out_ch.mean_rssi       = o_avg;
  assign out_ch.valid_count     = o_cnt;
endmodule

[hdl/rhsd_checker.sv]
// Port-level checks for the detector top level, attached by bind.
// Depends on the top level's ports only.
module rhsd_port_props (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_in_range,
  input logic       out_det,
  input logic [5:0] out_cnt
);
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> !out_det && out_cnt == 6'd0)
    else $error("out-of-range result not zero");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second transfer without result");
endmodule

bind rssi_history_signal_detector_top rhsd_port_props u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_in_range(out_ch.in_range),
  .out_det(out_ch.video_detected), .out_cnt(out_ch.valid_count)
);
